FILE: rtl/core/bilp_pkg.sv
`timescale 1ns / 1ps

package bilp_pkg;

  localparam int unsigned NUM_OPCODES = 181;
  localparam logic [24:0] SEEN_MAX    = 25'h1FF_FFFF;

  typedef enum logic [3:0] {
    K_NONE       = 4'd0,
    K_STR8       = 4'd1,
    K_STR16      = 4'd2,
    K_STR24      = 4'd3,
    K_HIDDEN     = 4'd4,
    K_BLK8       = 4'd5,
    K_BLK16      = 4'd6,
    K_BLK24      = 4'd7,
    K_THREAD     = 4'd8,
    K_LOCALNAME  = 4'd9,
    K_MODULENAME = 4'd10,
    K_STATICNAME = 4'd11
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_OP    = 3'd1,
    ERR_NO_RULE   = 3'd2,
    ERR_TOO_SHORT = 3'd3,
    ERR_TRUNC     = 3'd4
  } err_t;

  // table entries: fixed length, zero for no size rule, or variable marker plus kind
  localparam logic [7:0] VAR_FLAG = 8'h80;
  localparam logic [7:0] S8  = 8'h81;
  localparam logic [7:0] S16 = 8'h82;
  localparam logic [7:0] S24 = 8'h83;
  localparam logic [7:0] HID = 8'h84;
  localparam logic [7:0] B8  = 8'h85;
  localparam logic [7:0] B16 = 8'h86;
  localparam logic [7:0] B24 = 8'h87;
  localparam logic [7:0] TS  = 8'h88;
  localparam logic [7:0] LN  = 8'h89;
  localparam logic [7:0] MN  = 8'h8A;
  localparam logic [7:0] SN  = 8'h8B;
  localparam logic [7:0] PD  = 8'd11;

  localparam logic [7:0] OP_TABLE [NUM_OPCODES] = '{
    8'd1, 8'd1, 8'd1, 8'd3, 8'd3, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd1, 8'd3, 8'd2, 8'd3, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd3,
    8'd2, 8'd1, 8'd9, 8'd1, 8'd1, 8'd2, 8'd3, 8'd4, 8'd2, 8'd3,
    8'd4, 8'd2, 8'd3, 8'd4, 8'd1, 8'd1, 8'd3, LN,   8'd2, 8'd2,
    8'd2, 8'd3, 8'd2, 8'd1, 8'd2, 8'd2, 8'd1, 8'd1, 8'd3, 8'd1,
    8'd1, MN,   8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd0,
    8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd1, 8'd4, 8'd1, 8'd1, 8'd1, 8'd3, 8'd2, 8'd3, 8'd3, 8'd3,
    8'd2, 8'd3, 8'd3, 8'd3, 8'd1, 8'd1, 8'd3, 8'd2, 8'd3, B16,
    B8,   8'd3, 8'd2, 8'd3, 8'd3, 8'd2, 8'd3, 8'd5, 8'd3, 8'd3,
    8'd1, PD,   8'd1, 8'd3, 8'd3, S16,  S8,   8'd3, 8'd2, 8'd3,
    8'd1, 8'd3, 8'd2, 8'd4, 8'd4, 8'd1, 8'd3, 8'd5, SN,   8'd1,
    8'd1, 8'd1, 8'd1, 8'd3, 8'd3, 8'd0, 8'd4, 8'd1, 8'd9, 8'd3,
    8'd1, 8'd1, 8'd1, 8'd3, 8'd5, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd1, 8'd1, 8'd1, 8'd1, 8'd3, 8'd1, 8'd3, 8'd1, 8'd1, 8'd3,
    8'd4, 8'd4, HID,  8'd5, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd0,
    8'd0, B24,  S24,  8'd2, 8'd1, 8'd1, 8'd4, 8'd4, 8'd1, 8'd1,
    8'd1, 8'd1, 8'd1, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd1, TS,
    8'd1
  };

  function automatic logic [2:0] hdr_len(input kind_t k);
    logic [2:0] h;
    if (k == K_STR8 || k == K_BLK8) begin
      h = 3'd2;
    end else if (k == K_STR16 || k == K_BLK16 || k == K_THREAD) begin
      h = 3'd3;
    end else begin
      h = 3'd4;
    end
    return h;
  endfunction

endpackage

FILE: rtl/core/bilp_in_if.sv
`timescale 1ns / 1ps

interface bilp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       end_of_code;

  modport source (output valid, output code_byte, output end_of_code, input ready);
  modport sink (input valid, input code_byte, input end_of_code, output ready);
endinterface

FILE: rtl/core/bilp_out_if.sv
`timescale 1ns / 1ps

interface bilp_out_if;
  logic        valid;
  logic        ready;
  logic        starts_instruction;
  logic        ends_instruction;
  logic [7:0]  current_opcode;
  logic [24:0] instr_length;
  logic [2:0]  error_code;
  logic        last;

  modport source (
    output valid, output starts_instruction, output ends_instruction,
    output current_opcode, output instr_length, output error_code, output last,
    input ready
  );
  modport sink (
    input valid, input starts_instruction, input ends_instruction,
    input current_opcode, input instr_length, input error_code, input last,
    output ready
  );
endinterface

FILE: rtl/core/bytecode_instruction_length_parser_top.sv
`timescale 1ns / 1ps
// the result of an accepted byte is registered in the output register
// throughput: one byte per cycle while the sink keeps taking results, set by the single parse-state update per byte
// a new byte is taken while the held result is being taken by the sink
// reset (rst_n low, synchronous) empties the output register and returns the
// parser to expect-opcode with all counters cleared

module bytecode_instruction_length_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  bilp_in_if.sink     in_chan,
  bilp_out_if.source  out_chan
);

  typedef enum logic [2:0] {
    PH_OPCODE = 3'd0,
    PH_BODY   = 3'd1,
    PH_HEADER = 3'd2,
    PH_PREFIX = 3'd3,
    PH_NAME   = 3'd4
  } phase_t;

  phase_t         phase_r, phase_nxt;
  bilp_pkg::kind_t kind_r, kind_nxt;
  logic [7:0]     opcode_r, opcode_nxt;
  logic [24:0]    seen_r, seen_nxt;
  logic [24:0]    remain_r, remain_nxt;
  logic [23:0]    accum_r, accum_nxt;

  logic           out_valid_r;
  logic           start_r, start_nxt;
  logic           end_r, end_nxt;
  logic [7:0]     op_out_r;
  logic [24:0]    len_r, len_nxt;
  bilp_pkg::err_t err_r, err_nxt;
  logic           last_r;

  logic           in_acc;
  logic [7:0]     b;
  logic           eoc;
  logic [7:0]     entry;
  logic [2:0]     h;
  logic [24:0]    pos;
  logic [24:0]    first;
  logic [24:0]    cnt;
  logic [1:0]     lane;
  logic [25:0]    total;

  assign b      = in_chan.code_byte;
  assign eoc    = in_chan.end_of_code;
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_acc = in_chan.valid && in_chan.ready;

  assign entry = (b < 8'(bilp_pkg::NUM_OPCODES)) ? bilp_pkg::OP_TABLE[b] : 8'h00;
  assign h     = bilp_pkg::hdr_len(kind_r);

  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    opcode_nxt = opcode_r;
    seen_nxt   = seen_r;
    remain_nxt = remain_r;
    accum_nxt  = accum_r;
    start_nxt  = 1'b0;
    end_nxt    = 1'b0;
    len_nxt    = '0;
    err_nxt    = bilp_pkg::ERR_NONE;
    pos        = '0;
    first      = '0;
    cnt        = '0;
    lane       = '0;
    total      = '0;

    if (phase_r != PH_OPCODE && seen_r != bilp_pkg::SEEN_MAX) begin
      seen_nxt = seen_r + 25'd1;
    end

    unique case (phase_r)
      PH_OPCODE: begin
        start_nxt  = 1'b1;
        opcode_nxt = b;
        seen_nxt   = 25'd1;
        remain_nxt = '0;
        accum_nxt  = '0;
        kind_nxt   = bilp_pkg::K_NONE;
        if (b >= 8'(bilp_pkg::NUM_OPCODES)) begin
          err_nxt = bilp_pkg::ERR_BAD_OP;
          end_nxt = 1'b1;
          len_nxt = 25'd1;
        end else if (entry == 8'h00) begin
          err_nxt = bilp_pkg::ERR_NO_RULE;
          end_nxt = 1'b1;
          len_nxt = 25'd1;
        end else if ((entry & bilp_pkg::VAR_FLAG) != 8'h00) begin
          kind_nxt = bilp_pkg::kind_t'(entry[3:0]);
          if (kind_nxt == bilp_pkg::K_LOCALNAME) begin
            remain_nxt = 25'd2;
            phase_nxt  = PH_PREFIX;
          end else if (kind_nxt == bilp_pkg::K_STATICNAME) begin
            remain_nxt = 25'd3;
            phase_nxt  = PH_PREFIX;
          end else if (kind_nxt == bilp_pkg::K_MODULENAME) begin
            phase_nxt = PH_NAME;
          end else begin
            phase_nxt = PH_HEADER;
          end
        end else if (entry == 8'd1) begin
          end_nxt = 1'b1;
          len_nxt = 25'd1;
        end else begin
          remain_nxt = 25'(entry[6:0]) - 25'd1;
          phase_nxt  = PH_BODY;
        end
      end
      PH_BODY: begin
        if (remain_r != '0) begin
          remain_nxt = remain_r - 25'd1;
        end
        if (remain_nxt == '0) begin
          end_nxt = 1'b1;
          len_nxt = seen_nxt;
        end
      end
      PH_PREFIX: begin
        if (remain_r != '0) begin
          remain_nxt = remain_r - 25'd1;
        end
        if (remain_nxt == '0) begin
          phase_nxt = PH_NAME;
        end
      end
      PH_NAME: begin
        if (b == 8'h00) begin
          end_nxt = 1'b1;
          len_nxt = seen_nxt;
        end
      end
      PH_HEADER: begin
        pos   = seen_nxt - 25'd1;
        first = (kind_r == bilp_pkg::K_HIDDEN) ? 25'd2 : 25'd1;
        cnt   = 25'(h) - first;
        lane  = pos[1:0] - first[1:0];
        if (pos >= first && pos < first + cnt) begin
          unique case (lane)
            2'd0:    accum_nxt[7:0]   = accum_r[7:0] | b;
            2'd1:    accum_nxt[15:8]  = accum_r[15:8] | b;
            2'd2:    accum_nxt[23:16] = accum_r[23:16] | b;
            default: accum_nxt = accum_r;
          endcase
        end
        if (seen_nxt >= 25'(h)) begin
          if (kind_r == bilp_pkg::K_BLK8 || kind_r == bilp_pkg::K_BLK16 ||
              kind_r == bilp_pkg::K_BLK24) begin
            total = 26'(accum_nxt);
          end else if (kind_r == bilp_pkg::K_THREAD) begin
            total = 26'd3 + {1'b0, accum_nxt, 1'b0};
          end else begin
            total = 26'(accum_nxt) + 26'(h);
          end
          if (total < 26'(h)) begin
            err_nxt = bilp_pkg::ERR_TOO_SHORT;
            end_nxt = 1'b1;
            len_nxt = 25'(h);
          end else if (total == 26'(h)) begin
            end_nxt = 1'b1;
            len_nxt = 25'(h);
          end else begin
            remain_nxt = total[24:0] - 25'(h);
            phase_nxt  = PH_BODY;
          end
        end
      end
      default: begin
        phase_nxt = PH_OPCODE;
      end
    endcase

    if (!end_nxt && eoc) begin
      err_nxt = bilp_pkg::ERR_TRUNC;
      end_nxt = 1'b1;
      len_nxt = seen_nxt;
    end
    if (end_nxt || eoc) begin
      phase_nxt  = PH_OPCODE;
      seen_nxt   = '0;
      remain_nxt = '0;
      accum_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_OPCODE;
      kind_r      <= bilp_pkg::K_NONE;
      opcode_r    <= '0;
      seen_r      <= '0;
      remain_r    <= '0;
      accum_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r     <= phase_nxt;
        kind_r      <= kind_nxt;
        opcode_r    <= opcode_nxt;
        seen_r      <= seen_nxt;
        remain_r    <= remain_nxt;
        accum_r     <= accum_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      start_r  <= start_nxt;
      end_r    <= end_nxt;
      op_out_r <= opcode_nxt;
      len_r    <= len_nxt;
      err_r    <= err_nxt;
      last_r   <= eoc;
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.starts_instruction = start_r;
  assign out_chan.ends_instruction   = end_r;
  assign out_chan.current_opcode     = op_out_r;
  assign out_chan.instr_length       = len_r;
  assign out_chan.error_code         = err_r;
  assign out_chan.last               = last_r;

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted transaction produced no result");

  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && err_r == bilp_pkg::ERR_TRUNC |-> last_r && end_r)
    else $error("truncation reported away from end of code");

  a_len_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !end_r |-> len_r == '0)
    else $error("length reported on a non-final byte");

  a_open_counts: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_OPCODE |-> seen_r != '0)
    else $error("open instruction with no bytes counted");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && eoc |=> phase_r == PH_OPCODE && seen_r == '0)
    else $error("parser not cleared after end of code");

endmodule
